[rtl/core/viaf_pkg.sv]
`default_nettype none
package viaf_pkg;

    localparam int LANES = 4;
    localparam int DW = 64;
    localparam int DIV_STAGES = 64;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_AND = 4'd1, OP_OR = 4'd2, OP_XOR = 4'd3,
        OP_DIV = 4'd4, OP_LAND = 4'd5, OP_LOR = 4'd6, OP_MOD = 4'd7,
        OP_MUL = 4'd8, OP_SHL = 4'd9, OP_SHR = 4'd10, OP_SUB = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        T_I32 = 2'd0, T_U32 = 2'd1, T_I64 = 2'd2, T_BOOL = 2'd3
    } etype_t;

    typedef enum logic [1:0] {
        F_VV = 2'd0, F_VS = 2'd1, F_SV = 2'd2, F_SS = 2'd3
    } form_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_DIVZ = 3'd1, ST_MODZ = 3'd2,
        ST_NEGSH = 3'd3, ST_BIGSH = 3'd4, ST_UNSUP = 3'd5
    } status_t;

    // control carried alongside each lane through the pipeline
    typedef struct packed {
        logic [3:0] op;
        logic [1:0] etype;
        logic       sg;
        logic       used;
        logic       neg_q;
        logic       neg_r;
    } lane_ctl_t;

    // lane outcome handed to the merge stage
    typedef struct packed {
        logic [2:0]    status;
        logic [DW-1:0] res;
    } lane_out_t;

    function automatic logic [DW-1:0] norm_val(input logic [1:0] t, input logic [DW-1:0] v);
        logic [DW-1:0] r;
        case (t)
            T_I32:   r = {{32{v[31]}}, v[31:0]};
            T_U32:   r = {32'd0, v[31:0]};
            T_I64:   r = v;
            default: r = {63'd0, (v != '0)};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/vector_integer_alu_fold_unit.sv]
`default_nettype none
// A request passes the lane stage-zero registers, the 64-stage lane dividers and the output register.
// Throughput: one request per cycle; the whole pipeline advances when the
// output register is free or being taken.
// Reset: aresetn (synchronous, active low) clears the pipeline valid bits;
// payload registers are not reset.
module vector_integer_alu_fold_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // op[3:0], elem_type[5:4], form[7:6], lane_count[10:8],
    // lhs_lane0..3 from bit 11, rhs_lane0..3 from bit 267 (523 bits, padded to 528)
    input  wire logic [527:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // res_lane0..3, status (res_lane0 at bit 0; 259 bits padded to 264)
    output logic [263:0]       m_tdata
);
    localparam int DW = viaf_pkg::DW;
    localparam int NL = viaf_pkg::LANES;
    localparam int DEPTH = viaf_pkg::DIV_STAGES + 1;

    logic [3:0] op;
    logic [1:0] etype, form;
    logic [2:0] lc;
    logic       unsup;
    logic       adv;

    // unpack the request
    always_comb begin
        op    = s_tdata[3:0];
        etype = s_tdata[5:4];
        form  = s_tdata[7:6];
        lc    = s_tdata[10:8];
        unsup = 1'b0;
        if (form != viaf_pkg::F_SS && (lc == 3'd0 || lc > 3'(NL))) unsup = 1'b1;
        if (op > viaf_pkg::OP_SUB) unsup = 1'b1;
        if ((form == viaf_pkg::F_VS || form == viaf_pkg::F_SV) &&
            !(op == viaf_pkg::OP_DIV || op == viaf_pkg::OP_MOD || op == viaf_pkg::OP_MUL))
            unsup = 1'b1;
        if (op == viaf_pkg::OP_LAND || op == viaf_pkg::OP_LOR) begin
            if (etype != viaf_pkg::T_BOOL) unsup = 1'b1;
        end else if (etype == viaf_pkg::T_BOOL) begin
            unsup = 1'b1;
        end
    end

    logic m_valid_reg;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;

    viaf_pkg::lane_out_t lane_out [NL];
    for (genvar i = 0; i < NL; i++) begin : g_lane
        logic used;
        logic [DW-1:0] av, bv;
        always_comb begin
            used = !unsup && ((form == viaf_pkg::F_SS) ? (i == 0) : (3'(i) < lc));
            av = (form == viaf_pkg::F_SV || form == viaf_pkg::F_SS) ? s_tdata[11 +: DW]
                                                                    : s_tdata[11 + i*DW +: DW];
            bv = (form == viaf_pkg::F_VS || form == viaf_pkg::F_SS) ? s_tdata[11 + NL*DW +: DW]
                                                                    : s_tdata[11 + (NL+i)*DW +: DW];
        end
        viaf_lane u_lane (
            .aclk(aclk), .adv(adv), .in_used(used), .in_op(op), .in_etype(etype),
            .in_a(av), .in_b(bv), .out(lane_out[i])
        );
    end

    // carry valid and the unsupported flag along the lane pipeline
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] uns_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) uns_reg <= {uns_reg[DEPTH-2:0], unsup};
    end

    logic [2:0]    st;
    logic [DW-1:0] res [NL];
    viaf_merge u_merge (.unsup(uns_reg[DEPTH-1]), .lane(lane_out), .status(st), .res(res));

    // output register
    logic [263:0] m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[DEPTH-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) m_data_reg <= {5'd0, st, res[3], res[2], res[1], res[0]};
    end
    assign m_tdata = m_data_reg;

    // an unsupported request leaves with the unsupported status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vld_reg[DEPTH-1] && uns_reg[DEPTH-1]) |=> m_tdata[258:256] == viaf_pkg::ST_UNSUP)
        else $error("unsupported request lost its status");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[258:256] != viaf_pkg::ST_OK) |-> m_tdata[255:0] == '0)
        else $error("failing result carries lane data");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped under stall");
endmodule
`default_nettype wire

[rtl/core/viaf_lane.sv]
`default_nettype none
// One lane: operand decode, fast ops, 32x32 partial products and a
// radix-2 restoring divider unrolled one bit per pipeline stage.
module viaf_lane (
    input  wire logic                     aclk,
    input  wire logic                     adv,
    input  wire logic                     in_used,
    input  wire logic [3:0]               in_op,
    input  wire logic [1:0]               in_etype,
    input  wire logic [viaf_pkg::DW-1:0]  in_a,
    input  wire logic [viaf_pkg::DW-1:0]  in_b,
    output viaf_pkg::lane_out_t           out
);
    localparam int DW = viaf_pkg::DW;
    localparam int NS = viaf_pkg::DIV_STAGES;

    logic [DW-1:0] a, b;
    logic          sg;
    logic [DW-1:0] fast_res;
    logic [2:0]    fast_st;
    logic [DW-1:0] amag, bmag;

    always_comb begin
        a  = viaf_pkg::norm_val(in_etype, in_a);
        b  = viaf_pkg::norm_val(in_etype, in_b);
        sg = (in_etype == viaf_pkg::T_I32) || (in_etype == viaf_pkg::T_I64);
        amag = (sg && a[DW-1]) ? (~a + 1'b1) : a;
        bmag = (sg && b[DW-1]) ? (~b + 1'b1) : b;
    end

    // compute the fast ops, the divide-by-zero checks and the shift checks
    always_comb begin
        fast_res = '0;
        fast_st  = viaf_pkg::ST_OK;
        case (in_op)
            viaf_pkg::OP_ADD:  fast_res = a + b;
            viaf_pkg::OP_SUB:  fast_res = a - b;
            viaf_pkg::OP_AND:  fast_res = a & b;
            viaf_pkg::OP_OR:   fast_res = a | b;
            viaf_pkg::OP_XOR:  fast_res = a ^ b;
            viaf_pkg::OP_LAND: fast_res = {63'd0, (a != '0) && (b != '0)};
            viaf_pkg::OP_LOR:  fast_res = {63'd0, (a != '0) || (b != '0)};
            viaf_pkg::OP_DIV:  if (b == '0) fast_st = viaf_pkg::ST_DIVZ;
            viaf_pkg::OP_MOD:  if (b == '0) fast_st = viaf_pkg::ST_MODZ;
            viaf_pkg::OP_SHL, viaf_pkg::OP_SHR: begin
                if (sg && b[DW-1]) begin
                    fast_st = viaf_pkg::ST_NEGSH;
                end else if (b >= ((in_etype == viaf_pkg::T_I64) ? 64'd64 : 64'd32)) begin
                    fast_st = viaf_pkg::ST_BIGSH;
                end else if (in_op == viaf_pkg::OP_SHL) begin
                    fast_res = a << b[5:0];
                end else if (sg) begin
                    fast_res = $signed(a) >>> b[5:0];
                end else begin
                    fast_res = a >> b[5:0];
                end
            end
            default: fast_res = '0;
        endcase
        fast_res = viaf_pkg::norm_val(in_etype, fast_res);
    end

    // divider pipeline: stage k resolves quotient bit DW-1-k
    viaf_pkg::lane_ctl_t ctl_reg [NS+1];
    logic [DW-1:0] rem_reg [NS+1];
    logic [DW-1:0] quo_reg [NS+1];
    logic [DW-1:0] dvs_reg [NS+1];
    logic [DW-1:0] fres_reg [NS+1];
    logic [2:0]    fst_reg [NS+1];

    // hold the inputs in stage zero
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg[0]  <= '{op: in_op, etype: in_etype, sg: sg, used: in_used,
                             neg_q: sg && (a[DW-1] ^ b[DW-1]), neg_r: sg && a[DW-1]};
            rem_reg[0]  <= '0;
            quo_reg[0]  <= amag;
            dvs_reg[0]  <= bmag;
            fres_reg[0] <= fast_res;
            fst_reg[0]  <= fast_st;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [DW:0] trial;
        logic [DW:0] sh;
        always_comb begin
            sh    = {rem_reg[k], quo_reg[k][DW-1]};
            trial = sh - {1'b0, dvs_reg[k]};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                ctl_reg[k+1]  <= ctl_reg[k];
                rem_reg[k+1]  <= trial[DW] ? sh[DW-1:0] : trial[DW-1:0];
                quo_reg[k+1]  <= {quo_reg[k][DW-2:0], ~trial[DW]};
                dvs_reg[k+1]  <= dvs_reg[k];
                fst_reg[k+1]  <= fst_reg[k];
                fres_reg[k+1] <= fres_reg[k];
            end
        end
    end

    // separate multiply pipeline: lo*lo, lo*hi, hi*lo, then sum
    logic [DW-1:0] ll_reg, lh_reg, hl_reg, prod_reg;
    logic [DW-1:0] prod_dly [NS-1];
    always_ff @(posedge aclk) begin
        if (adv) begin
            ll_reg   <= a[31:0] * b[31:0];
            lh_reg   <= {32'd0, a[31:0] * b[63:32]};
            hl_reg   <= {32'd0, a[63:32] * b[31:0]};
            prod_reg <= ll_reg + {lh_reg[31:0] + hl_reg[31:0], 32'd0};
            prod_dly[0] <= viaf_pkg::norm_val(ctl_reg[1].etype, prod_reg);
            for (int i = 1; i < NS - 1; i++) prod_dly[i] <= prod_dly[i-1];
        end
    end

    // select the lane result at the pipeline end
    viaf_pkg::lane_ctl_t c;
    logic [DW-1:0] q, r;
    always_comb begin
        c = ctl_reg[NS];
        q = c.neg_q ? (~quo_reg[NS] + 1'b1) : quo_reg[NS];
        r = c.neg_r ? (~rem_reg[NS] + 1'b1) : rem_reg[NS];
        out.status = c.used ? fst_reg[NS] : viaf_pkg::ST_OK;
        case (c.op)
            viaf_pkg::OP_DIV: out.res = viaf_pkg::norm_val(c.etype, q);
            viaf_pkg::OP_MOD: out.res = viaf_pkg::norm_val(c.etype, r);
            viaf_pkg::OP_MUL: out.res = prod_dly[NS-2];
            default:          out.res = fres_reg[NS];
        endcase
        if (!c.used) out.res = '0;
    end
endmodule
`default_nettype wire

[rtl/core/viaf_merge.sv]
`default_nettype none
// Merge: an unsupported request, or else the lowest-numbered failing lane, sets status and zeroes every result.
module viaf_merge (
    input  wire logic                        unsup,
    input  wire viaf_pkg::lane_out_t         lane [viaf_pkg::LANES],
    output logic [2:0]                       status,
    output logic [viaf_pkg::DW-1:0]          res [viaf_pkg::LANES]
);
    always_comb begin
        status = unsup ? viaf_pkg::ST_UNSUP : viaf_pkg::ST_OK;
        for (int i = viaf_pkg::LANES - 1; i >= 0; i--) begin
            if (!unsup && lane[i].status != viaf_pkg::ST_OK) status = lane[i].status;
        end
        for (int i = 0; i < viaf_pkg::LANES; i++) begin
            res[i] = (status == viaf_pkg::ST_OK) ? lane[i].res : '0;
        end
    end
endmodule
`default_nettype wire
